// File: design/swf_pkg.sv
// shared types, constants and helper functions of the sigma window filter
package swf_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 12;
  localparam logic [10:0] WidthReset  = 11'd640;
  localparam logic [11:0] HeightReset = 12'd480;

  // reciprocal of nine for the mean: sum * 7282 >> 16 is exact below 2304
  localparam logic [12:0] Recip9Mean = 13'd7282;
  // reciprocal of nine for the variance: sq * 932068 >> 23, exact below 2^20
  localparam logic [19:0] Recip9Var  = 20'd932068;

  // allowed deviation is this many sigma
  localparam logic [1:0] SigmaSpan = 2'd2;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       start_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] filtered_value;
    logic       last_of_frame;
  } pix_out_t;

  // per-stage control that travels with the window
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  typedef logic [8:0][7:0] win_t;

  // partial state of the digit-by-digit square root
  typedef struct packed {
    logic [15:0] op;
    logic [15:0] res;
  } sqrt_t;

  // four steps of the integer square root, starting at bit weight one0
  function automatic sqrt_t sqrt_steps(sqrt_t s, logic [15:0] one0);
    sqrt_t       r;
    logic [15:0] one;
    logic [16:0] t;
    r   = s;
    one = one0;
    for (int i = 0; i < 4; i++) begin
      t = {1'b0, r.res} + {1'b0, one};
      if ({1'b0, r.op} >= t) begin
        r.op  = r.op - t[15:0];
        r.res = (r.res >> 1) + one;
      end else begin
        r.res = r.res >> 1;
      end
      one = one >> 2;
    end
    return r;
  endfunction

  // ceil(65536 / c) for counts of one to nine
  function automatic logic [16:0] recip_cnt(logic [3:0] c);
    logic [16:0] r;
    case (c)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/swf_front.sv
// raster counters, line store and 3x3 window register
module swf_front #(
  parameter int unsigned MAX_LINE_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [swf_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_acc_i,
  input  swf_pkg::pix_in_t               in_data_i,
  output swf_pkg::ctl_t                  ctl_o,
  output swf_pkg::win_t                  win_o
);

  localparam int unsigned AddrW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;

  logic [10:0] width_q;
  logic [11:0] height_q;
  logic [10:0] col_q, col_d, col_cur;
  logic [11:0] row_q, row_d, row_cur;
  logic [31:0] eff_w, eff_h, colx;
  logic [AddrW-1:0] addr;
  logic        emit, last;

  logic [15:0] mem_q [MAX_LINE_WIDTH];

  logic             v1_q;
  logic [7:0]       pix1_q;
  logic             emit1_q, last1_q;
  logic [AddrW-1:0] addr1_q;
  logic [15:0]      rd1_q;
  logic             wr;
  logic [15:0]      wdata;

  swf_pkg::ctl_t ctl2_q;
  swf_pkg::win_t win_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= swf_pkg::WidthReset;
      height_q <= swf_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swf_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[10:0];
        swf_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // effective frame size, position and counter advance
  always_comb begin
    eff_w = 32'(width_q);
    if (eff_w < 32'd3) eff_w = 32'd3;
    if (eff_w > MAX_LINE_WIDTH) eff_w = MAX_LINE_WIDTH;
    eff_h = (height_q < 12'd3) ? 32'd3 : 32'(height_q);
    col_cur = in_data_i.start_of_frame ? 11'd0 : col_q;
    row_cur = in_data_i.start_of_frame ? 12'd0 : row_q;
    colx = 32'(col_cur);
    addr = (colx >= MAX_LINE_WIDTH) ? AddrW'(MAX_LINE_WIDTH - 1) : AddrW'(colx);
    emit = (row_cur >= 12'd2) && (col_cur >= 11'd2);
    last = (32'(row_cur) + 32'd1 >= eff_h) && (colx + 32'd1 >= eff_w);
    if (colx + 32'd1 >= eff_w) begin
      col_d = '0;
      row_d = (32'(row_cur) + 32'd1 >= eff_h) ? 12'd0 : row_cur + 12'd1;
    end else begin
      col_d = col_cur + 11'd1;
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line store write when the item leaves the first stage
  assign wr    = en_i && v1_q;
  assign wdata = {rd1_q[7:0], pix1_q};

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[addr1_q] <= wdata;
  end

  // line store read with bypass of a write to the same column
  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      rd1_q   <= (wr && (addr1_q == addr)) ? wdata : mem_q[addr];
      pix1_q  <= in_data_i.pixel_value;
      emit1_q <= emit;
      last1_q <= last;
      addr1_q <= addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= in_acc_i;
  end

  // window shift, column 2 newest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl2_q.valid <= v1_q && emit1_q;
      ctl2_q.last  <= last1_q;
      if (v1_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]   <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= rd1_q[15:8];
        win_q[5] <= rd1_q[7:0];
        win_q[8] <= pix1_q;
      end
    end
  end

  assign ctl_o = ctl2_q;
  assign win_o = win_q;

endmodule

// File: design/swf_stats.sv
// window mean, variance and sigma over seven stages
module swf_stats (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  swf_pkg::ctl_t ctl_i,
  input  swf_pkg::win_t win_i,
  output swf_pkg::ctl_t ctl_o,
  output swf_pkg::win_t win_o,
  output logic [7:0]    sigma_o
);

  swf_pkg::ctl_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q, c7_q;
  swf_pkg::win_t w1_q, w2_q, w3_q, w4_q, w5_q, w6_q, w7_q;
  logic [11:0] sum_d, sum1_q;
  logic [24:0] mprod;
  logic [7:0]  mean2_q;
  logic [8:0][15:0] sqd_d, sqd3_q;
  logic [19:0] sq_d, sq4_q;
  logic [39:0] vprod;
  logic [15:0] var5_q;
  swf_pkg::sqrt_t s6_d, s6_q, s7_d;
  logic [7:0]  sig7_q;
  logic [7:0]  d;

  // combinational work of each stage
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 9; i++) sum_d = sum_d + 12'(win_i[i]);
    mprod = 25'(sum1_q) * 25'(swf_pkg::Recip9Mean);
    for (int i = 0; i < 9; i++) begin
      d = (w2_q[i] >= mean2_q) ? w2_q[i] - mean2_q : mean2_q - w2_q[i];
      sqd_d[i] = 16'(d) * 16'(d);
    end
    sq_d = '0;
    for (int i = 0; i < 9; i++) sq_d = sq_d + 20'(sqd3_q[i]);
    vprod = 40'(sq4_q) * 40'(swf_pkg::Recip9Var);
    s6_d = swf_pkg::sqrt_steps('{op: var5_q, res: 16'd0}, 16'h4000);
    s7_d = swf_pkg::sqrt_steps(s6_q, 16'h0040);
  end

  // valid and last bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0; c2_q <= '0; c3_q <= '0; c4_q <= '0;
      c5_q <= '0; c6_q <= '0; c7_q <= '0;
    end else if (en_i) begin
      c1_q <= ctl_i; c2_q <= c1_q; c3_q <= c2_q; c4_q <= c3_q;
      c5_q <= c4_q; c6_q <= c5_q; c7_q <= c6_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w1_q <= win_i; w2_q <= w1_q; w3_q <= w2_q; w4_q <= w3_q;
      w5_q <= w4_q; w6_q <= w5_q; w7_q <= w6_q;
      sum1_q  <= sum_d;
      mean2_q <= mprod[23:16];
      sqd3_q  <= sqd_d;
      sq4_q   <= sq_d;
      var5_q  <= vprod[38:23];
      s6_q    <= s6_d;
      sig7_q  <= s7_d.res[7:0];
    end
  end

  assign ctl_o   = c7_q;
  assign win_o   = w7_q;
  assign sigma_o = sig7_q;

endmodule

// File: design/swf_select.sv
// selection of pixels near the centre and their truncated average
module swf_select (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  swf_pkg::ctl_t     ctl_i,
  input  swf_pkg::win_t     win_i,
  input  logic [7:0]        sigma_i,
  output logic              valid_o,
  output swf_pkg::pix_out_t data_o
);

  swf_pkg::ctl_t c1_q, c2_q, c3_q;
  logic [8:0]  limit;
  logic [7:0]  d;
  logic [11:0] sum_d, sum1_q;
  logic [3:0]  cnt_d, cnt1_q;
  logic [28:0] prod_d, prod2_q;
  logic [7:0]  res3_q;

  // masked sum and count, then reciprocal multiply
  always_comb begin
    limit = 9'(sigma_i) * 9'(swf_pkg::SigmaSpan);
    sum_d = '0;
    cnt_d = '0;
    for (int i = 0; i < 9; i++) begin
      d = (win_i[i] >= win_i[4]) ? win_i[i] - win_i[4] : win_i[4] - win_i[i];
      if (9'(d) <= limit) begin
        sum_d = sum_d + 12'(win_i[i]);
        cnt_d = cnt_d + 4'd1;
      end
    end
    prod_d = 29'(sum1_q) * 29'(swf_pkg::recip_cnt(cnt1_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0; c2_q <= '0; c3_q <= '0;
    end else if (en_i) begin
      c1_q <= ctl_i; c2_q <= c1_q; c3_q <= c2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum1_q  <= sum_d;
      cnt1_q  <= cnt_d;
      prod2_q <= prod_d;
      res3_q  <= prod2_q[23:16];
    end
  end

  assign valid_o               = c3_q.valid;
  assign data_o.filtered_value = res3_q;
  assign data_o.last_of_frame  = c3_q.last;

endmodule

// File: design/sigma_window_filter_3x3.sv
// top level of the 3x3 sigma window filter
// usage:
// pixels enter in raster order on the input channel (in_valid_i / in_stall_o),
// start_of_frame puts a pixel at row 0, column 0; frames may also follow
// back to back once the configured height has been counted.
// one result leaves on the output channel (out_valid_o / out_stall_i) for
// every pixel that completes an interior window, i.e. row and column >= 2;
// the result belongs to the pixel one line up and one column left.
// last_of_frame marks the result of the last pixel of the frame.
// image_width and image_height are written through cfg_we_i while idle.
// throughput: one pixel per clock while in_stall_o is low; after the transfer of
// the pixel that completes a window, its result passes through the line store
// read, the window register, seven statistics stages, three select stages
// and the output register before out_valid_o rises.
// a stalled result is held in the output register; the next one parks in a
// skid register, and while that is full the whole pipeline and in_stall_o
// hold, so nothing is lost or repeated.
// reset clears counters, valid bits and the window; sizes return to 640x480;
// line store contents are undefined until written.
module sigma_window_filter_3x3 #(
  parameter int unsigned MAX_LINE_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [swf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  swf_pkg::pix_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output swf_pkg::pix_out_t            out_data_o
);

  logic              en, in_acc, p_v;
  swf_pkg::ctl_t     f_ctl, s_ctl;
  swf_pkg::win_t     f_win, s_win;
  logic [7:0]        sigma;
  swf_pkg::pix_out_t p_d, out_q, sk_q;
  logic              out_v_q, sk_v_q;

  // pipeline advances while the skid register is empty
  assign en         = !sk_v_q;
  assign in_stall_o = sk_v_q;
  assign in_acc     = in_valid_i && !sk_v_q;

  swf_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_acc_i(in_acc), .in_data_i,
    .ctl_o(f_ctl), .win_o(f_win)
  );

  swf_stats u_stats (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(f_ctl), .win_i(f_win),
    .ctl_o(s_ctl), .win_o(s_win), .sigma_o(sigma)
  );

  swf_select u_select (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(s_ctl), .win_i(s_win), .sigma_i(sigma),
    .valid_o(p_v), .data_o(p_d)
  );

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (sk_v_q) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end else begin
        out_v_q <= p_v;
      end
    end else if (p_v) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= sk_v_q ? sk_q : p_d;
    end else if (p_v && !sk_v_q) begin
      sk_q <= p_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: design/swf_checker.sv
// port-level checks of the sigma window filter and their bind
module swf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input swf_pkg::pix_out_t out_data_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input stall only while a result waits
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // input stall only starts after an output stall
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output stall");

  // a drained output frees the input on the next cycle
  a_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after drain");

endmodule

bind sigma_window_filter_3x3 swf_checker u_swf_checker (.*);

// File: dv/tb.sv
// testbench of the 3x3 sigma window filter: stimulus, prediction and checking
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LineMax   = 1024;
  localparam int unsigned DrainWait = 30;
  localparam int unsigned StallCap  = 3000;
  // index that maps to no register, writes to it are dropped
  localparam logic [1:0]  CfgSpareIdx = 2'd3;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [1:0]                   cfg_idx_i;
  logic [swf_pkg::CfgDataW-1:0] cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  swf_pkg::pix_in_t             in_data_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  swf_pkg::pix_out_t            out_data_o;

  sigma_window_filter_3x3 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  logic [10:0] width_reg;
  logic [11:0] height_reg;
  logic [15:0] line_mem [LineMax];
  logic [7:0]  win [9];
  int unsigned col_cnt;
  int unsigned row_cnt;

  swf_pkg::pix_out_t filtered_q[$];
  int unsigned err_cnt;
  int unsigned pix_cnt;
  int unsigned res_cnt;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          no_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch on %s at result %0d: got %0d, want %0d", what, res_cnt, got, want);
    err_cnt++;
  endtask

  function automatic int unsigned isqrt(input int unsigned v);
    int unsigned s;
    s = 0;
    while ((s + 1) * (s + 1) <= v) s++;
    return s;
  endfunction

  // window statistics and the sigma-limited average
  function automatic logic [7:0] sigma_average();
    int unsigned sum, mean, sq, d, lim, cnt, acc;
    sum = 0;
    sq  = 0;
    acc = 0;
    cnt = 0;
    for (int i = 0; i < 9; i++) sum += win[i];
    mean = sum / 9;
    for (int i = 0; i < 9; i++) begin
      d  = (win[i] >= mean) ? win[i] - mean : mean - win[i];
      sq += d * d;
    end
    lim = 2 * isqrt(sq / 9);
    for (int i = 0; i < 9; i++) begin
      d = (win[i] >= win[4]) ? win[i] - win[4] : win[4] - win[i];
      if (d <= lim) begin
        acc += win[i];
        cnt++;
      end
    end
    return 8'(acc / cnt);
  endfunction

  // advance the predictor by one pixel, queue the result it causes
  function automatic void filter_step(input swf_pkg::pix_in_t it);
    int unsigned w, h, c;
    logic [15:0] stored;
    swf_pkg::pix_out_t r;
    w = (width_reg < 3) ? 3 : (width_reg > LineMax) ? LineMax : width_reg;
    h = (height_reg < 3) ? 3 : height_reg;
    if (it.start_of_frame) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = (col_cnt >= LineMax) ? LineMax - 1 : col_cnt;
    stored = line_mem[c];
    line_mem[c] = {stored[7:0], it.pixel_value};
    for (int rw = 0; rw < 3; rw++) begin
      win[rw*3]   = win[rw*3+1];
      win[rw*3+1] = win[rw*3+2];
    end
    win[2] = stored[15:8];
    win[5] = stored[7:0];
    win[8] = it.pixel_value;
    if (row_cnt >= 2 && col_cnt >= 2) begin
      r.filtered_value = sigma_average();
      r.last_of_frame  = (row_cnt + 1 >= h) && (col_cnt + 1 >= w);
      filtered_q.push_back(r);
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : ((row_cnt + 1) & 12'hfff);
    end else begin
      col_cnt = (col_cnt + 1) & 11'h7ff;
    end
  endfunction

  // one pixel transfer, with a random gap before it unless no_idle is set
  task automatic send_pixel(input logic [7:0] pix, input logic sof);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{pixel_value: pix, start_of_frame: sof};
    do @(posedge clk_i); while (in_stall_o);
    filter_step('{pixel_value: pix, start_of_frame: sof});
    pix_cnt++;
  endtask

  // wait for every expected result, then let the pipeline empty
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (filtered_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [swf_pkg::CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == swf_pkg::CFG_IMAGE_WIDTH) width_reg = val[10:0];
    else if (idx == swf_pkg::CFG_IMAGE_HEIGHT) height_reg = val[11:0];
  endtask

  task automatic set_size(input logic [swf_pkg::CfgDataW-1:0] w,
                          input logic [swf_pkg::CfgDataW-1:0] h);
    drain();
    write_reg(swf_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(swf_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  // a whole frame; kind 0 random, 1 smooth with outliers, 2 only extremes, 3 constant
  task automatic send_frame(input int unsigned n, input int kind, input logic [7:0] base,
                            input bit with_sof);
    logic [7:0] p;
    for (int unsigned i = 0; i < n; i++) begin
      case (kind)
        0:       p = 8'($urandom);
        1:       p = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                     : 8'(base + $urandom_range(0, 12));
        2:       p = $urandom_range(0, 1) ? 8'hff : 8'h00;
        default: p = base;
      endcase
      send_pixel(p, with_sof && i == 0);
    end
  endtask

  // flat frames at both ends of the pixel range, then a frame of only extremes
  task automatic test_flat_extremes();
    set_size(3, 3);
    send_frame(9, 3, 8'h00, 1'b1);
    send_frame(9, 3, 8'hff, 1'b1);
    send_frame(9, 2, 8'h00, 1'b1);
  endtask

  // sizes below the range and widths above the line store are clamped; the largest height is kept
  task automatic test_clamped_sizes();
    set_size(0, 1);
    send_frame(9, 0, 8'h00, 1'b1);
    set_size(2, 2);
    send_frame(9, 1, 8'h40, 1'b1);
    set_size(12'h7ff, 3);
    send_frame(40, 1, 8'h80, 1'b1);
    set_size(3, 12'hfff);
    send_frame(40, 0, 8'h00, 1'b1);
  endtask

  // a write to an unused index leaves the sizes alone
  task automatic test_spare_index();
    set_size(4, 3);
    write_reg(CfgSpareIdx, 12'h555);
    send_frame(12, 0, 8'h00, 1'b1);
  endtask

  // frames that follow without start_of_frame, and a restart mid-frame
  task automatic test_frame_sequencing();
    set_size(5, 4);
    no_idle = 1'b1;
    send_frame(20, 1, 8'h20, 1'b1);
    send_frame(20, 0, 8'h00, 1'b0);
    no_idle = 1'b0;
    send_frame(13, 0, 8'h00, 1'b1);
    send_frame(20, 2, 8'h00, 1'b1);
  endtask

  // random sizes and content, now and then an aborted frame
  task automatic test_random_frames();
    int unsigned w, h, n;
    while (pix_cnt < 1400) begin
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
      h = $urandom_range(3, 8);
      set_size(12'(w), 12'(h));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h) : w * h;
        send_frame(n, $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 2),
                   8'($urandom), 1'b1);
      end
      no_idle = 1'b0;
    end
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_q.size() == 0) begin
        report("unexpected transfer", out_data_o.filtered_value, 0);
      end else begin
        if (out_data_o.filtered_value != filtered_q[0].filtered_value)
          report("filtered_value", out_data_o.filtered_value, filtered_q[0].filtered_value);
        if (out_data_o.last_of_frame != filtered_q[0].last_of_frame)
          report("last_of_frame", out_data_o.last_of_frame, filtered_q[0].last_of_frame);
        void'(filtered_q.pop_front());
      end
      res_cnt++;
      stall_left = no_idle ? 0 : $urandom_range(0, 8);
      out_stall_i <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= (stall_left != 0);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallCap) begin
      $display("timeout with %0d results outstanding", filtered_q.size());
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = swf_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    width_reg   = swf_pkg::WidthReset;
    height_reg  = swf_pkg::HeightReset;
    for (int i = 0; i < LineMax; i++) line_mem[i] = '0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    err_cnt = 0;
    pix_cnt = 0;
    res_cnt = 0;
    stall_left = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_flat_extremes();
    test_clamped_sizes();
    test_spare_index();
    test_frame_sequencing();
    test_random_frames();
    drain();

    if (filtered_q.size() != 0) report("results never seen", filtered_q.size(), 0);
    $display("%0d pixels sent over flat, clamped, restarted and random frames", pix_cnt);
    $display("%0d filtered results compared, %0d mismatches", res_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/swf_pkg.sv
design/swf_front.sv
design/swf_stats.sv
design/swf_select.sv
design/sigma_window_filter_3x3.sv
design/swf_checker.sv
dv/tb.sv
